// ===== rtl/core/audio_frame_deinterleaver_defines.svh =====
// ----------------------------------------------------------------------------
// audio frame deinterleaver assertion macros
// shared property wrappers for the port checker, clocked on clk_i and
// disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef AUDIO_FRAME_DEINTERLEAVER_DEFINES_SVH
`define AUDIO_FRAME_DEINTERLEAVER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define AFD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/afd_pkg.sv =====
// ----------------------------------------------------------------------------
// afd_pkg
// shared constants, codes and structs of the audio frame deinterleaver
// ----------------------------------------------------------------------------
package afd_pkg;

  // byte store
  localparam int unsigned STORE_BYTES = 8192;
  localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);

  // register widths
  localparam int unsigned CODED_W   = 12;
  localparam int unsigned ROWS_W    = 8;
  localparam int unsigned FRAME_W   = 13;
  localparam int unsigned ALIGN_W   = 12;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;

  // datapath widths
  localparam int unsigned NUM_W     = ROWS_W + FRAME_W;      // rows * frame
  localparam int unsigned CNT_W     = $clog2(NUM_W + 1);     // divider steps
  localparam int unsigned CBASE_W   = ROWS_W + FRAME_W + 1;  // column * 2 * frame
  localparam int unsigned RBASE_W   = ROWS_W + CODED_W;      // row * coded
  localparam int unsigned WADDR_W   = CBASE_W + 1;
  localparam int unsigned RDBASE_W  = NUM_W;                 // never above rows * frame
  localparam int unsigned RADDR_W   = RDBASE_W + 1;
  localparam int unsigned COUNT_W   = 16;

  // register reset values
  localparam logic [CODED_W-1:0] CODED_RST = CODED_W'(38);
  localparam logic [ROWS_W-1:0]  ROWS_RST  = ROWS_W'(12);
  localparam logic [FRAME_W-1:0] FRAME_RST = FRAME_W'(228);
  localparam logic [ALIGN_W-1:0] ALIGN_RST = ALIGN_W'(38);

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_END   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_EMPTY   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODED = 2'd0,
    REG_ROWS  = 2'd1,
    REG_FRAME = 2'd2,
    REG_ALIGN = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CODED_W-1:0] coded;
    logic [ROWS_W-1:0]  rows;
    logic [FRAME_W-1:0] frame;
    logic [ALIGN_W-1:0] align;
  } cfg_t;

  typedef struct packed {
    logic    use_mem;
    logic    valid;
    logic    last;
    status_e status;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/core/audio_frame_deinterleaver.sv =====
// ----------------------------------------------------------------------------
// audio_frame_deinterleaver
// byte-level deinterleaver for one block-interleaved audio superblock. Write
// transactions fill an 8192-byte store in stream order (row, then column,
// then byte), each byte landing at column * 2 * frame_bytes +
// row * coded_bytes + byte; once the superblock is complete, or an end
// transaction arrives, the block holds a number of packets and read
// transactions return them byte by byte, packet_bytes per packet, with tlast
// on the final byte. Every input transaction gives exactly one output
// transaction. One transaction is taken per clock in steady state while
// m_axis_tready is high: an input register and an output register sit either
// side of a combinational processing step, and all addresses come from
// incrementally updated bases, so the limit is the single store port pair.
// After reset the store is cleared, one byte per cycle, then the expected
// packet count is worked out before the first transaction is taken. A
// configuration write outside the clear phase rebuilds the address bases and
// reruns the packet-count division, holding tready low until it is done.
// Closing a superblock (last byte or end transaction) holds input processing
// through the S_IDX and S_RBASE states while the read base is rebuilt.
// ----------------------------------------------------------------------------
module audio_frame_deinterleaver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] in_byte
  input  logic [1:0]                     s_axis_tuser,   // [1:0] action
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [7:0] out_byte
  output logic                           m_axis_tlast,   // last_of_packet
  output logic [2:0]                     m_axis_tuser,   // [0] out_valid, [2:1] status
  // configuration
  input  logic                           cfg_we_i,
  input  logic [afd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [afd_pkg::CFG_W-1:0]      cfg_data_i
);
  import afd_pkg::*;

  // configuration registers
  cfg_t cfg_q;

  // input register
  logic    inv_q;
  action_e act_q;
  logic [7:0] byte_q;

  // output register
  logic outv_q;
  res_t res_q;

  logic     run;
  logic     proc;
  res_t     res;
  mem_req_t mem_req;
  logic [7:0] rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coded <= CODED_RST;
      cfg_q.rows  <= ROWS_RST;
      cfg_q.frame <= FRAME_RST;
      cfg_q.align <= ALIGN_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CODED: cfg_q.coded <= cfg_data_i[CODED_W-1:0];
        REG_ROWS:  cfg_q.rows  <= cfg_data_i[ROWS_W-1:0];
        REG_FRAME: cfg_q.frame <= cfg_data_i[FRAME_W-1:0];
        REG_ALIGN: cfg_q.align <= cfg_data_i[ALIGN_W-1:0];
      endcase
    end
  end

  // an item is processed when the engine runs and the output slot is free
  // or being emptied this cycle
  assign proc          = run && inv_q && (!outv_q || m_axis_tready);
  assign s_axis_tready = run && (!inv_q || proc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      inv_q <= 1'b1;
    end else if (proc) begin
      inv_q <= 1'b0;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      act_q  <= action_e'(s_axis_tuser);
      byte_q <= s_axis_tdata;
    end
  end

  afd_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cfg_wr_i (cfg_we_i),
    .step_i   (proc),
    .act_i    (act_q),
    .byte_i   (byte_q),
    .run_o    (run),
    .res_o    (res),
    .mem_o    (mem_req)
  );

  // read data is registered inside the store, alongside the result register
  afd_store u_store (
    .clk_i   (clk_i),
    .mem_i   (mem_req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outv_q <= 1'b0;
    end else if (proc) begin
      outv_q <= 1'b1;
    end else if (m_axis_tready) begin
      outv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = outv_q;
  // out of range reads and non-read results give a zero byte
  assign m_axis_tdata  = res_q.use_mem ? rdata : '0;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tuser  = {res_q.status, res_q.valid};

endmodule

// ===== rtl/core/afd_divider.sv =====
// ----------------------------------------------------------------------------
// afd_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module afd_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [afd_pkg::NUM_W-1:0]    num_i,
  input  logic [afd_pkg::ALIGN_W-1:0]  den_i,
  output logic                         done_o,
  output logic [afd_pkg::NUM_W-1:0]    quo_o
);
  import afd_pkg::*;

  logic [NUM_W-1:0]   quo_q;
  logic [ALIGN_W-1:0] rem_q;
  logic [ALIGN_W-1:0] den_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [ALIGN_W:0]   trial;
  logic [ALIGN_W:0]   diff;
  logic               ge;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      quo_q  <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
      cnt_q  <= CNT_W'(NUM_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      quo_q  <= {quo_q[NUM_W-2:0], ge};
      rem_q  <= ge ? diff[ALIGN_W-1:0] : trial[ALIGN_W-1:0];
      cnt_q  <= cnt_q - CNT_W'(1);
      busy_q <= cnt_q != CNT_W'(1);
      done_q <= cnt_q == CNT_W'(1);
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/core/afd_store.sv =====
// ----------------------------------------------------------------------------
// afd_store
// superblock byte store, one write and one registered read port
// ----------------------------------------------------------------------------
module afd_store (
  input  logic              clk_i,
  input  afd_pkg::mem_req_t mem_i,
  output logic [7:0]        rdata_o
);
  import afd_pkg::*;

  logic [7:0] mem_q [STORE_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_i.we) begin
      mem_q[mem_i.waddr] <= mem_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_i.re) begin
      rdata_q <= mem_q[mem_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/afd_engine.sv =====
// ----------------------------------------------------------------------------
// afd_engine
// write and read counters, address bases, packet bookkeeping and setup
// sequencer
// ----------------------------------------------------------------------------
module afd_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  afd_pkg::cfg_t     cfg_i,
  input  logic              cfg_wr_i,
  input  logic              step_i,
  input  afd_pkg::action_e  act_i,
  input  logic [7:0]        byte_i,
  output logic              run_o,
  output afd_pkg::res_t     res_o,
  output afd_pkg::mem_req_t mem_o
);
  import afd_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_NUM,
    S_DIV,
    S_IDX,
    S_RBASE,
    S_RUN
  } state_e;

  state_e st_q, st_d;

  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [CODED_W-1:0]  byte_q, byte_d;
  logic [ROWS_W-1:0]   col_q, col_d;
  logic [ROWS_W-1:0]   row_q, row_d;
  logic [COUNT_W-1:0]  frames_q, frames_d;
  logic [COUNT_W-1:0]  pend_q, pend_d;
  logic [ALIGN_W-1:0]  roff_q, roff_d;
  logic [CBASE_W-1:0]  cbase_q, cbase_d;
  logic [RBASE_W-1:0]  rowbase_q, rowbase_d;
  logic [RDBASE_W-1:0] rdbase_q, rdbase_d;
  logic [NUM_W-1:0]    exp_q, exp_d;
  logic [NUM_W-1:0]    idx_q, idx_d;

  // effective register values
  logic [CODED_W-1:0] coded_eff;
  logic [ALIGN_W-1:0] align_eff;
  logic [ROWS_W-1:0]  rows_eff;
  logic [ROWS_W-1:0]  cols_eff;

  logic [NUM_W-1:0]          num;
  logic                      div_done;
  logic [NUM_W-1:0]          div_quo;
  logic [CBASE_W-1:0]        cprod;
  logic [RBASE_W-1:0]        rprod;
  logic [NUM_W+ALIGN_W-1:0]  dprod;
  logic [WADDR_W-1:0]        waddr_full;
  logic [RADDR_W-1:0]        raddr_full;
  logic [RDBASE_W:0]         rdsum;
  logic                      w_in;
  logic                      r_in;
  logic [CODED_W:0]          b1;
  logic [ROWS_W:0]           c1;
  logic [ROWS_W:0]           r1;
  logic [ALIGN_W:0]          o1;
  logic [COUNT_W-1:0]        frames_nx;
  logic                      close;
  logic                      exp_ge_pend;

  assign coded_eff = (cfg_i.coded == '0) ? CODED_W'(1) : cfg_i.coded;
  assign align_eff = (cfg_i.align == '0) ? ALIGN_W'(1) : cfg_i.align;
  assign rows_eff  = (cfg_i.rows == '0) ? ROWS_W'(1) : cfg_i.rows;
  assign cols_eff  = (cfg_i.rows[ROWS_W-1:1] == '0) ? ROWS_W'(1)
                                                    : {1'b0, cfg_i.rows[ROWS_W-1:1]};

  // expected packet count: rows * frame / align
  assign num = NUM_W'(cfg_i.rows) * NUM_W'(cfg_i.frame);

  afd_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (st_q == S_NUM),
    .num_i   (num),
    .den_i   (align_eff),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // base rebuilds after a register change or a closed superblock
  assign cprod = CBASE_W'(col_q) * CBASE_W'(cfg_i.frame);
  assign rprod = RBASE_W'(row_q) * RBASE_W'(cfg_i.coded);
  assign dprod = (NUM_W + ALIGN_W)'(idx_q) * (NUM_W + ALIGN_W)'(align_eff);

  assign waddr_full = WADDR_W'(cbase_q) + WADDR_W'(rowbase_q) + WADDR_W'(byte_q);
  assign raddr_full = RADDR_W'(rdbase_q) + RADDR_W'(roff_q);
  assign w_in       = waddr_full < WADDR_W'(STORE_BYTES);
  assign r_in       = raddr_full < RADDR_W'(STORE_BYTES);
  assign rdsum      = (RDBASE_W + 1)'(rdbase_q) + (RDBASE_W + 1)'(align_eff);

  assign b1 = {1'b0, byte_q} + (CODED_W + 1)'(1);
  assign c1 = {1'b0, col_q} + (ROWS_W + 1)'(1);
  assign r1 = {1'b0, row_q} + (ROWS_W + 1)'(1);
  assign o1 = {1'b0, roff_q} + (ALIGN_W + 1)'(1);

  assign exp_ge_pend = exp_q >= NUM_W'(pend_q);

  always_comb begin
    st_d      = st_q;
    clr_d     = clr_q;
    byte_d    = byte_q;
    col_d     = col_q;
    row_d     = row_q;
    frames_d  = frames_q;
    pend_d    = pend_q;
    roff_d    = roff_q;
    cbase_d   = cbase_q;
    rowbase_d = rowbase_q;
    rdbase_d  = rdbase_q;
    exp_d     = exp_q;
    idx_d     = idx_q;
    frames_nx = frames_q;
    close     = 1'b0;

    res_o.use_mem = 1'b0;
    res_o.valid   = 1'b0;
    res_o.last    = 1'b0;
    res_o.status  = ST_OK;

    mem_o.we    = 1'b0;
    mem_o.waddr = waddr_full[ADDR_W-1:0];
    mem_o.wdata = byte_i;
    mem_o.re    = 1'b0;
    mem_o.raddr = raddr_full[ADDR_W-1:0];

    unique case (st_q)
      S_CLEAR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = clr_q;
        mem_o.wdata = '0;
        clr_d       = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(STORE_BYTES - 1)) begin
          st_d = S_NUM;
        end
      end
      S_NUM: begin
        cbase_d   = {cprod[CBASE_W-2:0], 1'b0};
        rowbase_d = rprod;
        st_d      = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          exp_d = div_quo;
          st_d  = S_IDX;
        end
      end
      S_IDX: begin
        idx_d = exp_ge_pend ? exp_q - NUM_W'(pend_q) : '0;
        st_d  = S_RBASE;
      end
      S_RBASE: begin
        rdbase_d = dprod[RDBASE_W-1:0];
        st_d     = S_RUN;
      end
      S_RUN: begin
        if (step_i) begin
          unique case (act_i)
            ACT_WRITE: begin
              if (pend_q != '0) begin
                res_o.status = ST_REFUSED;
              end else begin
                if (byte_q == '0 && frames_q != '1) begin
                  frames_nx = frames_q + COUNT_W'(1);
                end
                frames_d = frames_nx;
                mem_o.we = w_in;
                if (b1 >= {1'b0, coded_eff}) begin
                  byte_d = '0;
                  if (c1 >= {1'b0, cols_eff}) begin
                    col_d   = '0;
                    cbase_d = '0;
                    if (r1 >= {1'b0, rows_eff}) begin
                      close = 1'b1;
                    end else begin
                      row_d     = r1[ROWS_W-1:0];
                      rowbase_d = rowbase_q + RBASE_W'(cfg_i.coded);
                    end
                  end else begin
                    col_d   = c1[ROWS_W-1:0];
                    cbase_d = cbase_q + CBASE_W'({cfg_i.frame, 1'b0});
                  end
                end else begin
                  byte_d = b1[CODED_W-1:0];
                end
              end
            end
            ACT_READ: begin
              if (pend_q == '0) begin
                res_o.status = ST_EMPTY;
              end else begin
                res_o.valid   = 1'b1;
                res_o.use_mem = r_in;
                mem_o.re      = r_in;
                if (o1 >= {1'b0, align_eff}) begin
                  res_o.last = 1'b1;
                  roff_d     = '0;
                  pend_d     = pend_q - COUNT_W'(1);
                  // packet index saturates at zero when pending exceeds expected
                  rdbase_d   = exp_ge_pend ? rdsum[RDBASE_W-1:0] : '0;
                end else begin
                  roff_d = o1[ALIGN_W-1:0];
                end
              end
            end
            ACT_END: begin
              close = pend_q == '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        st_d = S_NUM;
      end
    endcase

    if (close) begin
      byte_d    = '0;
      col_d     = '0;
      row_d     = '0;
      frames_d  = '0;
      roff_d    = '0;
      cbase_d   = '0;
      rowbase_d = '0;
      pend_d    = (exp_q < NUM_W'(frames_nx)) ? exp_q[COUNT_W-1:0] : frames_nx;
      st_d      = S_IDX;
    end

    if (cfg_wr_i && st_q != S_CLEAR) begin
      st_d = S_NUM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_CLEAR;
      clr_q     <= '0;
      byte_q    <= '0;
      col_q     <= '0;
      row_q     <= '0;
      frames_q  <= '0;
      pend_q    <= '0;
      roff_q    <= '0;
      cbase_q   <= '0;
      rowbase_q <= '0;
      rdbase_q  <= '0;
      exp_q     <= '0;
      idx_q     <= '0;
    end else begin
      st_q      <= st_d;
      clr_q     <= clr_d;
      byte_q    <= byte_d;
      col_q     <= col_d;
      row_q     <= row_d;
      frames_q  <= frames_d;
      pend_q    <= pend_d;
      roff_q    <= roff_d;
      cbase_q   <= cbase_d;
      rowbase_q <= rowbase_d;
      rdbase_q  <= rdbase_d;
      exp_q     <= exp_d;
      idx_q     <= idx_d;
    end
  end

  assign run_o = st_q == S_RUN;

endmodule

// ===== rtl/core/afd_checker.sv =====
// ----------------------------------------------------------------------------
// afd_checker
// port-level checks on the deinterleaver output stream
// ----------------------------------------------------------------------------
`include "audio_frame_deinterleaver_defines.svh"

module afd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [2:0] m_axis_tuser
);
  import afd_pkg::*;

  logic        pkt_byte;
  logic        st_ok;
  logic        stalled;
  logic [12:0] beat;

  assign pkt_byte = m_axis_tuser[0];
  assign st_ok    = m_axis_tuser[2:1] == ST_OK;
  assign stalled  = m_axis_tvalid && !m_axis_tready;
  assign beat     = {m_axis_tvalid, m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // packet end only on a successful read
  `AFD_ASSERT_SAME(a_last_on_read, m_axis_tvalid && m_axis_tlast, pkt_byte && st_ok, "stray tlast")

  // bytes are zero unless they carry packet data
  `AFD_ASSERT_SAME(a_zero_byte, m_axis_tvalid && !pkt_byte, m_axis_tdata == 8'd0, "stray byte")

  // an error status never comes with packet data
  `AFD_ASSERT_SAME(a_err_data, m_axis_tvalid && !st_ok, !pkt_byte && !m_axis_tlast, "error data")

  // a stalled result stays put
  `AFD_ASSERT_NEXT(a_out_hold, stalled, $stable(beat), "output changed while stalled")

endmodule

bind audio_frame_deinterleaver afd_checker u_afd_checker (.*);
